// ===== rtl/ivm_pkg.sv =====
// Shared constants, codes and control structs of the interval value map.
`timescale 1ns / 1ps
package ivm_pkg;

  localparam int unsigned MAX_BREAKS_DEF = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 8;
  localparam int unsigned CFG_BITS       = 8;
  localparam int unsigned COUNT_BITS     = 5;
  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned STATUS_BITS    = 2;

  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ASSIGN = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_ENTRY,
    ADD_BEGIN,
    ADD_END
  } add_sel_e;

  typedef struct packed {
    logic     start;
    logic     adv;
    add_sel_e add_sel;
    logic     upd_end;
    logic     upd_found;
    logic     mark_empty;
    logic     clear_tbl;
    logic     commit;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               empty;
    logic               k_lt_kb;
    logic               k_le_ke;
    logic               k_le_kb;
    logic               at_end;
  } sts_t;

endpackage

// ===== rtl/ivm_datapath.sv =====
// Datapath: double-banked breakpoint memory, scan index, merge writer and result registers.
`timescale 1ns / 1ps
module ivm_datapath #(
  parameter int unsigned MAX_BREAKS = ivm_pkg::MAX_BREAKS_DEF,
  parameter int unsigned KEY_BITS   = ivm_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = ivm_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ivm_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  input  logic [ivm_pkg::OP_BITS-1:0]        opcode_i,
  input  logic [KEY_BITS-1:0]                key_begin_i,
  input  logic [KEY_BITS-1:0]                key_end_i,
  input  logic [VALUE_BITS-1:0]              new_value_i,
  input  ivm_pkg::cmd_t                      cmd_i,
  output ivm_pkg::sts_t                      sts_o,
  output logic [VALUE_BITS-1:0]              found_value_o,
  output logic [ivm_pkg::COUNT_BITS-1:0]     entry_count_o,
  output logic [ivm_pkg::STATUS_BITS-1:0]    status_o
);

  localparam int unsigned AW    = $clog2(MAX_BREAKS);
  localparam int unsigned CW    = $clog2(MAX_BREAKS + 1);
  localparam int unsigned MW    = KEY_BITS + VALUE_BITS;
  localparam int unsigned DEPTH = 2 ** (AW + 1);

  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata_q;

  logic [ivm_pkg::OP_BITS-1:0]     op_q;
  logic [KEY_BITS-1:0]             kb_q, ke_q;
  logic [VALUE_BITS-1:0]           nv_q;
  logic [ivm_pkg::CFG_BITS-1:0]    cfg_q;
  logic [AW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   wcnt_q;
  logic [VALUE_BITS-1:0]           lastv_q, endv_q, found_q;
  logic                            ovf_q;
  logic                            bank_q, fresh_q;
  logic [CW-1:0]                   used_q;
  logic [ivm_pkg::STATUS_BITS-1:0] stat_q;
  logic [VALUE_BITS-1:0]           out_found_q;
  logic [ivm_pkg::COUNT_BITS-1:0]  out_count_q;
  logic [ivm_pkg::STATUS_BITS-1:0] out_stat_q;

  logic [KEY_BITS-1:0]   rk, add_key;
  logic [VALUE_BITS-1:0] rv, add_val;
  logic                  add_dup, add_full, add_wr, mem_we;
  logic [AW:0]           waddr, raddr;
  logic [MW-1:0]         wdata;
  logic [CW+ivm_pkg::COUNT_BITS-1:0] used_wide;

  // Entry 0 of bank 0 is never written before the first clear or assign.
  assign rk = fresh_q ? '0 : rdata_q[MW-1:VALUE_BITS];
  assign rv = fresh_q ? '0 : rdata_q[VALUE_BITS-1:0];

  always_comb begin
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.adv) begin
      idx_d = idx_q + AW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_comb begin
    case (cmd_i.add_sel)
      ivm_pkg::ADD_BEGIN: begin
        add_key = kb_q;
        add_val = nv_q;
      end
      ivm_pkg::ADD_END: begin
        add_key = ke_q;
        add_val = endv_q;
      end
      default: begin
        add_key = rk;
        add_val = rv;
      end
    endcase
  end

  assign add_dup  = (wcnt_q != '0) && (lastv_q == add_val);
  assign add_full = (wcnt_q == CW'(MAX_BREAKS));
  assign add_wr   = (cmd_i.add_sel != ivm_pkg::ADD_NONE) && !add_dup && !add_full;
  assign mem_we   = add_wr || cmd_i.clear_tbl;
  assign waddr    = cmd_i.clear_tbl ? {bank_q, AW'(0)} : {~bank_q, wcnt_q[AW-1:0]};
  assign wdata    = cmd_i.clear_tbl ? {KEY_BITS'(0), VALUE_BITS'(cfg_q)} : {add_key, add_val};
  assign raddr    = {bank_q, idx_d};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.start) begin
      op_q    <= opcode_i;
      kb_q    <= key_begin_i;
      ke_q    <= key_end_i;
      nv_q    <= new_value_i;
      wcnt_q  <= '0;
      ovf_q   <= 1'b0;
      found_q <= '0;
      stat_q  <= ivm_pkg::ST_DONE;
    end else begin
      if (cmd_i.add_sel != ivm_pkg::ADD_NONE && !add_dup) begin
        if (add_full) begin
          ovf_q <= 1'b1;
        end else begin
          wcnt_q  <= wcnt_q + CW'(1);
          lastv_q <= add_val;
        end
      end
      if (cmd_i.upd_found) begin
        found_q <= rv;
      end
      if (cmd_i.mark_empty) begin
        stat_q <= ivm_pkg::ST_EMPTY;
      end
      if (cmd_i.commit && ovf_q) begin
        stat_q <= ivm_pkg::ST_FULL;
      end
    end
    if (cmd_i.upd_end) begin
      endv_q <= rv;
    end
    if (cmd_i.load_out) begin
      out_found_q <= found_q;
      out_count_q <= used_wide[ivm_pkg::COUNT_BITS-1:0];
      out_stat_q  <= stat_q;
    end
  end

  assign used_wide = (CW + ivm_pkg::COUNT_BITS)'(used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      bank_q  <= 1'b0;
      used_q  <= CW'(1);
      fresh_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_tbl) begin
        used_q  <= CW'(1);
        fresh_q <= 1'b0;
      end else if (cmd_i.commit && !ovf_q) begin
        bank_q  <= ~bank_q;
        used_q  <= wcnt_q;
        fresh_q <= 1'b0;
      end
    end
  end

  assign sts_o.op      = op_q;
  assign sts_o.empty   = (kb_q >= ke_q);
  assign sts_o.k_lt_kb = (rk < kb_q);
  assign sts_o.k_le_ke = (rk <= ke_q);
  assign sts_o.k_le_kb = (rk <= kb_q);
  assign sts_o.at_end  = ((CW'(idx_q) + CW'(1)) == used_q);

  assign found_value_o = out_found_q;
  assign entry_count_o = out_count_q;
  assign status_o      = out_stat_q;

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= CW'(MAX_BREAKS)))
    else $error("breakpoint count out of range");

  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !ovf_q && !cmd_i.clear_tbl) |=> (used_q == $past(wcnt_q)))
    else $error("committed count differs from merged count");

  a_merge_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_wr |-> (waddr[AW] != bank_q))
    else $error("merge write hit the live bank");
`endif

endmodule

// ===== rtl/ivm_ctrl.sv =====
// Controller: sequences lookup, merge scan and clear, and owns the handshakes.
`timescale 1ns / 1ps
module ivm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  ivm_pkg::sts_t sts_i,
  output ivm_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_POST
  } state_e;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_MID,
    PH_POST
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic   m_valid_q, m_valid_d;
  logic   step;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    ph_d      = ph_q;
    step      = 1'b0;
    m_valid_d = m_valid_q && !m_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.start = 1'b1;
          ph_d        = PH_PRE;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (sts_i.op)
          ivm_pkg::OP_LOOKUP: begin
            cmd_o.upd_found = sts_i.k_le_kb;
            step            = 1'b1;
          end
          ivm_pkg::OP_ASSIGN: begin
            if (sts_i.empty) begin
              cmd_o.mark_empty = 1'b1;
              state_d          = S_POST;
            end else begin
              unique case (ph_q)
                PH_PRE: begin
                  if (sts_i.k_lt_kb) begin
                    cmd_o.add_sel = ivm_pkg::ADD_ENTRY;
                    cmd_o.upd_end = 1'b1;
                    step          = 1'b1;
                  end else begin
                    cmd_o.add_sel = ivm_pkg::ADD_BEGIN;
                    ph_d          = PH_MID;
                  end
                end
                PH_MID: begin
                  if (sts_i.k_le_ke) begin
                    cmd_o.upd_end = 1'b1;
                    step          = 1'b1;
                  end else begin
                    cmd_o.add_sel = ivm_pkg::ADD_END;
                    ph_d          = PH_POST;
                  end
                end
                default: begin
                  cmd_o.add_sel = ivm_pkg::ADD_ENTRY;
                  step          = 1'b1;
                end
              endcase
            end
          end
          ivm_pkg::OP_CLEAR: begin
            cmd_o.clear_tbl = 1'b1;
            state_d         = S_POST;
          end
          default: begin
            state_d = S_POST;
          end
        endcase
        if (step) begin
          if (sts_i.at_end) begin
            state_d = (sts_i.op == ivm_pkg::OP_ASSIGN) ? S_TAIL : S_POST;
          end else begin
            cmd_o.adv = 1'b1;
          end
        end
      end
      S_TAIL: begin
        // Breakpoints still owed once every stored entry has been seen.
        unique case (ph_q)
          PH_PRE: begin
            cmd_o.add_sel = ivm_pkg::ADD_BEGIN;
            ph_d          = PH_MID;
          end
          PH_MID: begin
            cmd_o.add_sel = ivm_pkg::ADD_END;
            ph_d          = PH_POST;
          end
          default: begin
            cmd_o.commit = 1'b1;
            state_d      = S_POST;
          end
        endcase
      end
      S_POST: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ph_q      <= PH_PRE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

// ===== rtl/interval_value_map_unit.sv =====
// Top level of the interval value map: stream ports around controller and datapath.
`timescale 1ns / 1ps
// The block keeps a sorted breakpoint table that covers the whole key range and answers
// one result beat per input beat. The table lives in a memory of two banks; an assign
// reads the live bank one entry per cycle, holding the scan while it writes the new
// begin or end breakpoint, and writes the merged table into the other bank, which
// becomes live only if the result fits, so a full table stays unchanged. A new input
// beat is taken while the previous result still waits on the output.
module interval_value_map_unit #(
  parameter int unsigned MAX_BREAKS = ivm_pkg::MAX_BREAKS_DEF,
  parameter int unsigned KEY_BITS   = ivm_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = ivm_pkg::VALUE_BITS_DEF,
  localparam int unsigned IN_W  = ((ivm_pkg::OP_BITS + 2 * KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W =
    ((VALUE_BITS + ivm_pkg::COUNT_BITS + ivm_pkg::STATUS_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ivm_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // opcode, key_begin, key_end, new_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata   // found_value, entry_count, status
);

  ivm_pkg::cmd_t cmd;
  ivm_pkg::sts_t sts;

  logic [VALUE_BITS-1:0]           found_value;
  logic [ivm_pkg::COUNT_BITS-1:0]  entry_count;
  logic [ivm_pkg::STATUS_BITS-1:0] status;

  ivm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ivm_datapath #(
    .MAX_BREAKS (MAX_BREAKS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (s_axis_tdata[ivm_pkg::OP_BITS-1:0]),
    .key_begin_i   (s_axis_tdata[ivm_pkg::OP_BITS +: KEY_BITS]),
    .key_end_i     (s_axis_tdata[ivm_pkg::OP_BITS + KEY_BITS +: KEY_BITS]),
    .new_value_i   (s_axis_tdata[ivm_pkg::OP_BITS + 2 * KEY_BITS +: VALUE_BITS]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .found_value_o (found_value),
    .entry_count_o (entry_count),
    .status_o      (status)
  );

  assign m_axis_tdata = OUT_W'({status, entry_count, found_value});

endmodule

// ===== sim/interval_value_map_checker.sv =====
// Checker for the interval value map: predicts every result beat and compares it.
`timescale 1ns / 1ps
module interval_value_map_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          error_count_o,
  output int          pending_o
);

  localparam int DEPTH = 16;

  // Packed from the most significant bit down, so found_value sits in the lowest bits.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [7:0] found_value;
  } map_result_t;

  logic [31:0] tbl_keys[DEPTH];
  logic [7:0]  tbl_vals[DEPTH];
  int          tbl_count;
  logic [7:0]  dflt_value;
  map_result_t result_queue[$];
  logic [31:0] mrg_keys[DEPTH + 2];
  logic [7:0]  mrg_vals[DEPTH + 2];
  int          mrg_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count_o++;
  endtask

  function automatic logic [7:0] value_at(input logic [31:0] key);
    logic [7:0] v;
    v = tbl_vals[0];
    for (int i = 1; i < tbl_count; i++) begin
      if (tbl_keys[i] <= key) v = tbl_vals[i];
      else break;
    end
    return v;
  endfunction

  task automatic merge_add(input logic [31:0] key, input logic [7:0] val);
    if (mrg_count > 0 && mrg_vals[mrg_count - 1] == val) return;
    if (mrg_count < DEPTH + 2) begin
      mrg_keys[mrg_count] = key;
      mrg_vals[mrg_count] = val;
      mrg_count++;
    end
  endtask

  task automatic reset_table();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
    end
    tbl_vals[0] = dflt_value;
    tbl_count = 1;
  endtask

  task automatic assign_range(input logic [31:0] kb, input logic [31:0] ke,
                              input logic [7:0] nv, output logic [1:0] st);
    logic [7:0] tail_value;
    if (!(kb < ke)) begin
      st = ivm_pkg::ST_EMPTY;
      return;
    end
    tail_value = value_at(ke);
    mrg_count = 0;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_keys[i] < kb) merge_add(tbl_keys[i], tbl_vals[i]);
    merge_add(kb, nv);
    merge_add(ke, tail_value);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_keys[i] > ke) merge_add(tbl_keys[i], tbl_vals[i]);
    if (mrg_count > DEPTH) begin
      st = ivm_pkg::ST_FULL;
      return;
    end
    for (int i = 0; i < DEPTH; i++) begin
      tbl_keys[i] = (i < mrg_count) ? mrg_keys[i] : '0;
      tbl_vals[i] = (i < mrg_count) ? mrg_vals[i] : '0;
    end
    tbl_count = mrg_count;
    st = ivm_pkg::ST_DONE;
  endtask

  initial begin
    error_count_o = 0;
    dflt_value = '0;
    reset_table();
  end

  always @(posedge clk_i) begin
    map_result_t r, want;
    logic [1:0]  op;
    if (rst_ni) begin
      if (cfg_we_i) dflt_value = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        op = s_axis_tdata[1:0];
        r = '0;
        if (op == ivm_pkg::OP_LOOKUP) r.found_value = value_at(s_axis_tdata[33:2]);
        else if (op == ivm_pkg::OP_ASSIGN)
          assign_range(s_axis_tdata[33:2], s_axis_tdata[65:34], s_axis_tdata[73:66], r.status);
        else if (op == ivm_pkg::OP_CLEAR) reset_table();
        r.entry_count = tbl_count[4:0];
        result_queue.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        r = m_axis_tdata[14:0];
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result beat", r, 0);
        end else begin
          want = result_queue.pop_front();
          if (r.found_value != want.found_value)
            report_mismatch("found_value", r.found_value, want.found_value);
          if (r.entry_count != want.entry_count)
            report_mismatch("entry_count", r.entry_count, want.entry_count);
          if (r.status != want.status) report_mismatch("status", r.status, want.status);
        end
        if (m_axis_tdata[15] !== 1'b0) report_mismatch("pad bit", m_axis_tdata[15], 0);
      end
    end
    pending_o = result_queue.size();
  end
endmodule

// ===== sim/interval_value_map_unit_test.sv =====
// Testbench top of the interval value map: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module interval_value_map_unit_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          error_count, pending, cycle_count;
  logic [31:0] key_pool[8];

  always #1 clk_i = ~clk_i;

  interval_value_map_unit dut (.*);
  interval_value_map_checker checker_i (.*, .error_count_o(error_count), .pending_o(pending));

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // The beat is offered on a falling edge after a random gap that follows the withdrawal of the previous one.
  task automatic send_op(input logic [1:0] op, input logic [31:0] kb, input logic [31:0] ke,
                         input logic [7:0] nv);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk_i);
    s_axis_tdata <= {6'd0, nv, ke, kb, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_and_write(input logic [7:0] v);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return key_pool[$urandom_range(0, 7)];
      default: return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 3) - 1;
    endcase
  endfunction

  // Receiver stalls at random, with calm cycles drawn at random in which it never stalls.
  initial begin
    int calm;
    forever begin
      @(negedge clk_i);
      calm = $urandom_range(0, 3);
      if (calm == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 9) != 0) && ($urandom_range(0, 19) != 0 ||
                            gap_len() < 3);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] kb, ke;
    int sel;
    key_pool = '{32'h0, 32'h1, 32'h10, 32'h100, 32'h8000_0000, 32'hFFFF_FFFE,
                 32'hFFFF_FFFF, 32'h1234_5678};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, empty intervals, unused opcode and table full.
    send_op(ivm_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'h00);
    send_op(ivm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send_op(ivm_pkg::OP_ASSIGN, 32'h0, 32'hFFFF_FFFF, 8'hFF);
    send_op(ivm_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 8'h00);
    send_op(ivm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send_op(ivm_pkg::OP_ASSIGN, 32'h5, 32'h5, 8'h11);
    send_op(ivm_pkg::OP_ASSIGN, 32'h9, 32'h5, 8'h11);
    send_op(ivm_pkg::OP_ASSIGN, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'h00);
    send_op(ivm_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    for (int i = 0; i < 10; i++)
      send_op(ivm_pkg::OP_ASSIGN, 32'h100 * i + 32'h10, 32'h100 * i + 32'h20, 8'(i + 1));
    send_op(ivm_pkg::OP_LOOKUP, 32'h315, 32'h0, 8'h0);
    send_op(ivm_pkg::OP_ASSIGN, 32'h10, 32'h980, 8'h7);
    send_op(ivm_pkg::OP_CLEAR, 32'h0, 32'h0, 8'h0);
    drain_and_write(8'hFF);
    send_op(ivm_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_op(ivm_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0, 8'h0);
    // Random phases with different default values.
    for (int phase = 0; phase < 5; phase++) begin
      drain_and_write(phase == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
      send_op(ivm_pkg::OP_CLEAR, 32'h0, 32'h0, 8'h0);
      for (int n = 0; n < 100; n++) begin
        sel = $urandom_range(0, 19);
        kb = rand_key();
        ke = rand_key();
        if (sel < 9) begin
          if (kb > ke && $urandom_range(0, 3) != 0) {kb, ke} = {ke, kb};
          send_op(ivm_pkg::OP_ASSIGN, kb, ke, $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                  8'($urandom_range(0, 3)));
        end else if (sel < 17) begin
          send_op(ivm_pkg::OP_LOOKUP, kb, $urandom(), 8'($urandom()));
        end else if (sel < 18) begin
          send_op(ivm_pkg::OP_CLEAR, $urandom(), $urandom(), 8'($urandom()));
        end else begin
          send_op(ivm_pkg::OP_UNUSED, $urandom(), $urandom(), 8'($urandom()));
        end
        // Let the output side catch up completely once per phase.
        if (n == 50) while (pending != 0) @(negedge clk_i);
      end
    end
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== interval_value_map_unit.f =====
rtl/ivm_pkg.sv
rtl/ivm_datapath.sv
rtl/ivm_ctrl.sv
rtl/interval_value_map_unit.sv
sim/interval_value_map_checker.sv
sim/interval_value_map_unit_test.sv
